@@ rtl/core/huffman_tree_stream_decoder_macros.svh @@
// ----------------------------------------------------------------------------
// Huffman tree stream decoder assertion macros
// Shared concurrent assertion forms for the decoder core.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_TREE_STREAM_DECODER_MACROS_SVH
`define HUFFMAN_TREE_STREAM_DECODER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define HTSD_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define HTSD_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/htsd_pkg.sv @@
// ----------------------------------------------------------------------------
// Huffman tree stream decoder package
// Fixed field widths, packet length limits, character codes and event kinds of the decoder.
// ----------------------------------------------------------------------------
package htsd_pkg;

    // Field and port widths.
    localparam int CHAR_W      = 8;
    localparam int SYM_W       = 7;
    localparam int KIND_W      = 2;
    localparam int PLEN_W      = 13;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 8;

    // Packet length limits and reset value.
    localparam logic [PLEN_W-1:0] PLEN_MIN   = 13'd2;
    localparam logic [PLEN_W-1:0] PLEN_MAX   = 13'd4096;
    localparam logic [PLEN_W-1:0] PLEN_RESET = 13'd128;

    // Characters with a meaning in the stream.
    localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CH_ONE  = 8'h31;
    localparam logic [CHAR_W-1:0] CH_END  = 8'h7E;

    // Result event kinds.
    localparam logic [KIND_W-1:0] EV_SYMBOL   = 2'd0;
    localparam logic [KIND_W-1:0] EV_ERROR    = 2'd1;
    localparam logic [KIND_W-1:0] EV_END      = 2'd2;
    localparam logic [KIND_W-1:0] EV_OVERFLOW = 2'd3;

endpackage

@@ rtl/core/huffman_tree_stream_decoder.sv @@
// A result is written to the output register by the second step of its item, after the item
// is taken; that step is held while the output register still holds an unaccepted result.
// One item per cycle, except that an item that reads a node, writes a second node entry or
// reports an event holds s_tready low for a second step, set by the memory ports or the output.
// Reset (aresetn, synchronous, active low) clears all control state, the root entry and the
// packet length to 128; the node memory is not cleared, a node is written before it is read.
// ----------------------------------------------------------------------------
// Huffman tree stream decoder
// Builds a code tree in a node memory from a received code header, then walks
// it one received bit per item and reports decoded symbols and stop events.
// ----------------------------------------------------------------------------
`include "huffman_tree_stream_decoder_macros.svh"

module huffman_tree_stream_decoder #(
    parameter int SYMBOL_COUNT = 128,
    parameter int NODE_COUNT   = 256,
    parameter int LENGTH_BITS  = 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Configuration: packet length
    input  logic                                 cfg_wr_en,
    input  logic [htsd_pkg::PLEN_W-1:0]          cfg_wr_data,
    // Input stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [htsd_pkg::IN_TDATA_W-1:0]      s_tdata,   // [7:0] in_char
    // Result stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [htsd_pkg::OUT_TDATA_W-1:0]     m_tdata,   // [6:0] symbol, [7] zero
    output logic [htsd_pkg::KIND_W-1:0]          m_tuser    // [1:0] event_kind
);

    import htsd_pkg::*;

    localparam int NODE_W = $clog2(NODE_COUNT);
    localparam int NF_W   = NODE_W + 1;
    localparam int SIDX_W = $clog2(SYMBOL_COUNT + 1);
    localparam int LIDX_W = (LENGTH_BITS > 1) ? $clog2(LENGTH_BITS) : 1;

    // Decoder phases.
    localparam logic [2:0] PH_LEN    = 3'd0;
    localparam logic [2:0] PH_CODE   = 3'd1;
    localparam logic [2:0] PH_SKIP   = 3'd2;
    localparam logic [2:0] PH_DECODE = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;

    // Work done in the held second step of an item.
    localparam logic [1:0] BM_EMIT  = 2'd0;
    localparam logic [1:0] BM_WRITE = 2'd1;
    localparam logic [1:0] BM_CODE  = 2'd2;
    localparam logic [1:0] BM_DEC   = 2'd3;

    typedef struct packed {
        logic [NODE_W-1:0] left;
        logic [NODE_W-1:0] right;
        logic [SYM_W-1:0]  sym;
    } entry_t;

    // Node memory; the root lives in root_ent_reg and is never stored here.
    entry_t node_mem [NODE_COUNT];
    entry_t mem_rdata_reg;

    logic              mem_we;
    logic [NODE_W-1:0] mem_waddr;
    entry_t            mem_wdata;
    logic              mem_re;
    logic [NODE_W-1:0] mem_raddr;

    // State registers.
    logic [PLEN_W-1:0]      plen_reg;
    logic [PLEN_W-1:0]      pos_reg, pos_next;
    logic [2:0]             phase_reg, phase_next;
    logic [SIDX_W-1:0]      symidx_reg, symidx_next;
    logic [LIDX_W-1:0]      lidx_reg, lidx_next;
    logic [LENGTH_BITS-1:0] clen_reg, clen_next;
    logic [LENGTH_BITS-1:0] left_reg, left_next;
    logic [NODE_W-1:0]      cur_node_reg, cur_node_next;
    logic [NF_W-1:0]        nf_reg, nf_next;
    entry_t                 cur_ent_reg, cur_ent_next;
    entry_t                 root_ent_reg, root_ent_next;

    // Second-step control.
    logic                   busy_reg, busy_next;
    logic [1:0]             bmode_reg, bmode_next;
    logic [NODE_W-1:0]      bnode_reg, bnode_next;
    logic [SYM_W-1:0]       bsym_reg, bsym_next;
    logic                   bfin_reg, bfin_next;
    logic [KIND_W-1:0]      bkind_reg, bkind_next;

    // Output register.
    logic                   out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]      out_kind_reg, out_kind_next;
    logic [SYM_W-1:0]       out_sym_reg, out_sym_next;

    // Working signals.
    logic [PLEN_W-1:0]      plen_eff;
    logic                   is_zero, is_one;
    logic [NODE_W-1:0]      child;
    logic                   rd_leaf;
    logic                   out_free;
    logic                   emit_b;
    logic                   fin;
    logic [LENGTH_BITS-1:0] clen_new;
    logic [SIDX_W-1:0]      symidx_inc;
    entry_t                 par_ent;

    assign s_tready = !busy_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(out_sym_reg);
    assign m_tuser  = out_kind_reg;

    // Effective packet length, held to its legal range.
    always_comb begin
        if (plen_reg < PLEN_MIN) begin
            plen_eff = PLEN_MIN;
        end else if (plen_reg > PLEN_MAX) begin
            plen_eff = PLEN_MAX;
        end else begin
            plen_eff = plen_reg;
        end
    end

    assign is_zero    = (s_tdata == CH_ZERO);
    assign is_one     = (s_tdata == CH_ONE);
    assign child      = is_zero ? cur_ent_reg.left : cur_ent_reg.right;
    assign rd_leaf    = (mem_rdata_reg.left == '0) && (mem_rdata_reg.right == '0);
    assign out_free   = !out_valid_reg || m_tready;
    assign symidx_inc = symidx_reg + SIDX_W'(1);

    // Main control: second step of a held item, or a newly taken item.
    always_comb begin
        pos_next       = pos_reg;
        phase_next     = phase_reg;
        symidx_next    = symidx_reg;
        lidx_next      = lidx_reg;
        clen_next      = clen_reg;
        left_next      = left_reg;
        cur_node_next  = cur_node_reg;
        nf_next        = nf_reg;
        cur_ent_next   = cur_ent_reg;
        root_ent_next  = root_ent_reg;
        busy_next      = busy_reg;
        bmode_next     = bmode_reg;
        bnode_next     = bnode_reg;
        bsym_next      = bsym_reg;
        bfin_next      = bfin_reg;
        bkind_next     = bkind_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_kind_next  = out_kind_reg;
        out_sym_next   = out_sym_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = '0;
        emit_b         = 1'b0;
        fin            = 1'b0;
        clen_new       = clen_reg;
        par_ent        = cur_ent_reg;

        if (busy_reg) begin
            // Second step: memory data is in mem_rdata_reg.
            case (bmode_reg)
                BM_EMIT: begin
                    emit_b        = 1'b1;
                    out_kind_next = bkind_reg;
                    out_sym_next  = '0;
                end
                BM_WRITE: begin
                    // Freshly allocated final node of a code takes its symbol.
                    mem_we    = 1'b1;
                    mem_waddr = bnode_reg;
                    mem_wdata = '{left: '0, right: '0, sym: bsym_reg};
                end
                BM_CODE: begin
                    if (bfin_reg) begin
                        mem_we    = 1'b1;
                        mem_waddr = bnode_reg;
                        mem_wdata = '{left: mem_rdata_reg.left, right: mem_rdata_reg.right,
                                      sym: bsym_reg};
                    end else begin
                        cur_ent_next = mem_rdata_reg;
                    end
                end
                BM_DEC: begin
                    if (rd_leaf) begin
                        emit_b        = 1'b1;
                        out_kind_next = EV_SYMBOL;
                        out_sym_next  = mem_rdata_reg.sym;
                        cur_node_next = '0;
                        cur_ent_next  = root_ent_reg;
                    end else begin
                        cur_node_next = bnode_reg;
                        cur_ent_next  = mem_rdata_reg;
                    end
                end
                default: begin
                end
            endcase
            // Hold the item until the output register can take its result.
            if (!emit_b || out_free) begin
                busy_next = 1'b0;
                if (emit_b) begin
                    out_valid_next = 1'b1;
                end
            end else begin
                // The output register still holds an earlier result.
                out_kind_next = out_kind_reg;
                out_sym_next  = out_sym_reg;
            end
        end else if (s_tvalid) begin
            if (pos_reg >= plen_eff) begin
                // Check character: dropped, position restarts.
                pos_next = PLEN_W'(1);
            end else begin
                pos_next = pos_reg + PLEN_W'(1);
                case (phase_reg)
                    PH_LEN: begin
                        clen_new = clen_reg;
                        if (is_one) begin
                            clen_new[lidx_reg] = 1'b1;
                        end
                        clen_next = clen_new;
                        lidx_next = lidx_reg + LIDX_W'(1);
                        if (lidx_reg == LIDX_W'(LENGTH_BITS - 1)) begin
                            lidx_next = '0;
                            if (clen_new == '0) begin
                                // Empty code: the symbol belongs to the root.
                                root_ent_next.sym = SYM_W'(symidx_reg);
                                fin = 1'b1;
                            end else begin
                                left_next     = clen_new;
                                cur_node_next = '0;
                                cur_ent_next  = root_ent_reg;
                                phase_next    = PH_CODE;
                            end
                        end
                    end
                    PH_CODE: begin
                        if (is_zero || is_one) begin
                            left_next = left_reg - LENGTH_BITS'(1);
                            if (child == '0) begin
                                if (nf_reg == NF_W'(NODE_COUNT)) begin
                                    phase_next = PH_DONE;
                                    busy_next  = 1'b1;
                                    bmode_next = BM_EMIT;
                                    bkind_next = EV_OVERFLOW;
                                end else begin
                                    // Allocate a node and link it to its parent.
                                    nf_next = nf_reg + NF_W'(1);
                                    par_ent = cur_ent_reg;
                                    if (is_zero) begin
                                        par_ent.left = nf_reg[NODE_W-1:0];
                                    end else begin
                                        par_ent.right = nf_reg[NODE_W-1:0];
                                    end
                                    if (cur_node_reg == '0) begin
                                        root_ent_next = par_ent;
                                    end else begin
                                        mem_we    = 1'b1;
                                        mem_waddr = cur_node_reg;
                                        mem_wdata = par_ent;
                                    end
                                    cur_node_next = nf_reg[NODE_W-1:0];
                                    cur_ent_next  = '0;
                                    if (left_reg == LENGTH_BITS'(1)) begin
                                        busy_next  = 1'b1;
                                        bmode_next = BM_WRITE;
                                        bnode_next = nf_reg[NODE_W-1:0];
                                        bsym_next  = SYM_W'(symidx_reg);
                                        fin        = 1'b1;
                                    end
                                end
                            end else begin
                                // Existing child: fetch its entry.
                                mem_re        = 1'b1;
                                mem_raddr     = child;
                                busy_next     = 1'b1;
                                bmode_next    = BM_CODE;
                                bnode_next    = child;
                                bsym_next     = SYM_W'(symidx_reg);
                                bfin_next     = (left_reg == LENGTH_BITS'(1));
                                cur_node_next = child;
                                fin           = (left_reg == LENGTH_BITS'(1));
                            end
                        end
                    end
                    PH_SKIP: begin
                        if (is_one) begin
                            phase_next    = PH_DECODE;
                            cur_node_next = '0;
                            cur_ent_next  = root_ent_reg;
                        end
                    end
                    PH_DECODE: begin
                        if (s_tdata == CH_END) begin
                            phase_next = PH_DONE;
                            busy_next  = 1'b1;
                            bmode_next = BM_EMIT;
                            bkind_next = EV_END;
                        end else if (is_zero || is_one) begin
                            if (child == '0) begin
                                phase_next = PH_DONE;
                                busy_next  = 1'b1;
                                bmode_next = BM_EMIT;
                                bkind_next = EV_ERROR;
                            end else begin
                                mem_re     = 1'b1;
                                mem_raddr  = child;
                                busy_next  = 1'b1;
                                bmode_next = BM_DEC;
                                bnode_next = child;
                            end
                        end
                    end
                    default: begin
                    end
                endcase

                // Close the current symbol and move on to the next one.
                if (fin) begin
                    symidx_next   = symidx_inc;
                    lidx_next     = '0;
                    clen_next     = '0;
                    left_next     = '0;
                    cur_node_next = '0;
                    cur_ent_next  = root_ent_next;
                    phase_next    = (symidx_inc == SIDX_W'(SYMBOL_COUNT)) ? PH_SKIP : PH_LEN;
                end
            end
        end
    end

    // Node memory: one write and one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            node_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_rdata_reg <= node_mem[mem_raddr];
        end
    end

    // Packet length register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plen_reg <= PLEN_RESET;
        end else if (cfg_wr_en) begin
            plen_reg <= cfg_wr_data;
        end
    end

    // Control and state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= PLEN_W'(1);
            phase_reg     <= PH_LEN;
            symidx_reg    <= '0;
            lidx_reg      <= '0;
            clen_reg      <= '0;
            left_reg      <= '0;
            cur_node_reg  <= '0;
            nf_reg        <= NF_W'(1);
            cur_ent_reg   <= '0;
            root_ent_reg  <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            phase_reg     <= phase_next;
            symidx_reg    <= symidx_next;
            lidx_reg      <= lidx_next;
            clen_reg      <= clen_next;
            left_reg      <= left_next;
            cur_node_reg  <= cur_node_next;
            nf_reg        <= nf_next;
            cur_ent_reg   <= cur_ent_next;
            root_ent_reg  <= root_ent_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers of the second step and the output.
    always_ff @(posedge aclk) begin
        bmode_reg    <= bmode_next;
        bnode_reg    <= bnode_next;
        bsym_reg     <= bsym_next;
        bfin_reg     <= bfin_next;
        bkind_reg    <= bkind_next;
        out_kind_reg <= out_kind_next;
        out_sym_reg  <= out_sym_next;
    end

    // Assertions on the memory interlock and the phase sequence.
    `HTSD_ASSERT_IMP(a_no_root_write, aclk, aresetn, mem_we, mem_waddr != '0, "root entry written to node memory")
    `HTSD_ASSERT_IMP(a_port_excl, aclk, aresetn, mem_re, !mem_we, "node memory read and written in one cycle")
    `HTSD_ASSERT_NXT(a_read_holds, aclk, aresetn, mem_re, busy_reg, "node read not followed by a held item")
    `HTSD_ASSERT_NXT(a_done_sticky, aclk, aresetn, phase_reg == PH_DONE, phase_reg == PH_DONE, "decoder left the stopped phase")

endmodule
